### rtl/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared types and codes for the 3D box overlap table: item opcodes, the
// stored box layout and the memory entry layout.
// ----------------------------------------------------------------------------
package aabb_pkg;

    localparam int COORD_W = 32;
    localparam int SLOT_W  = 6;

    // Item opcodes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord min_x;
        t_coord min_y;
        t_coord min_z;
        t_coord max_x;
        t_coord max_y;
        t_coord max_z;
    } t_box;

    // One memory word: valid mark plus the box
    typedef struct packed {
        logic vld;
        t_box box;
    } t_entry;

endpackage

### rtl/aabb_box_mem.sv
// ----------------------------------------------------------------------------
// aabb_box_mem
// Box memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module aabb_box_mem #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [IDX_W-1:0]      i_waddr,
    input  aabb_pkg::t_entry      i_wdata,
    input  logic [IDX_W-1:0]      i_raddr,
    output aabb_pkg::t_entry      o_rdata
);
    import aabb_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/aabb_overlap.sv
// ----------------------------------------------------------------------------
// aabb_overlap
// Compares the query box against one stored entry on all three axes with the
// inclusive rule; an invalid or skipped entry never hits.
// ----------------------------------------------------------------------------
module aabb_overlap (
    input  aabb_pkg::t_box   i_query,
    input  aabb_pkg::t_entry i_entry,
    input  logic             i_skip,
    output logic             o_hit
);
    import aabb_pkg::*;

    function automatic logic axis_hit(t_coord amin, t_coord amax,
                                      t_coord bmin, t_coord bmax);
        logic a_in_b;
        logic b_in_a;
        a_in_b = (amin >= bmin) && (amin <= bmax);
        b_in_a = (bmin >= amin) && (bmin <= amax);
        return a_in_b || b_in_a;
    endfunction

    logic hit_x;
    logic hit_y;
    logic hit_z;

    // Check each axis independently
    assign hit_x = axis_hit(i_query.min_x, i_query.max_x,
                            i_entry.box.min_x, i_entry.box.max_x);
    assign hit_y = axis_hit(i_query.min_y, i_query.max_y,
                            i_entry.box.min_y, i_entry.box.max_y);
    assign hit_z = axis_hit(i_query.min_z, i_query.max_z,
                            i_entry.box.min_z, i_entry.box.max_z);

    assign o_hit = i_entry.vld && !i_skip && hit_x && hit_y && hit_z;

endmodule

### rtl/aabb_overlap_query_table.sv
// ----------------------------------------------------------------------------
// aabb_overlap_query_table
// Table of 3D axis-aligned boxes in a single memory. Add items write a slot;
// test items scan every slot and report whether any valid box overlaps.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  input   | in        | i_valid / o_stall  | i_op i_slot i_skip_self i_min_* i_max_*
//  result  | out       | o_valid / i_stall  | o_hit
//
//  Add: from accept through S_DONE to the output register. Test: scanned through
//  the box memory's single read port, one entry per cycle, then through S_DONE.
//  After reset the memory is cleared entry by entry with o_stall high.
//  A finished result waits in the output register while i_stall is high;
//  the next item is accepted meanwhile.
// ----------------------------------------------------------------------------
module aabb_overlap_query_table #(
    parameter int ENTRIES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_op,
    input  logic [aabb_pkg::SLOT_W-1:0]     i_slot,
    input  logic                            i_skip_self,
    input  aabb_pkg::t_coord                i_min_x,
    input  aabb_pkg::t_coord                i_min_y,
    input  aabb_pkg::t_coord                i_min_z,
    input  aabb_pkg::t_coord                i_max_x,
    input  aabb_pkg::t_coord                i_max_y,
    input  aabb_pkg::t_coord                i_max_z,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_hit
);
    import aabb_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRIES - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state            r_state,     n_state;
    logic [CNT_W-1:0]  r_idx,       n_idx;
    logic [IDX_W-1:0]  r_pidx,      n_pidx;
    logic              r_pend,      n_pend;
    logic              r_hit,       n_hit;
    logic              r_out_valid, n_out_valid;
    logic              r_out_hit,   n_out_hit;
    t_box              r_query,     n_query;
    logic [SLOT_W-1:0] r_slot,      n_slot;
    logic              r_skip,      n_skip;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    t_entry            mem_wdata;
    t_entry            mem_rdata;
    t_box              in_box;
    logic [31:0]       in_slot_ext;
    logic              in_slot_ok;
    logic              skip_cur;
    logic              cmp_hit;
    logic              out_free;

    assign in_box      = '{min_x: i_min_x, min_y: i_min_y, min_z: i_min_z,
                           max_x: i_max_x, max_y: i_max_y, max_z: i_max_z};
    assign in_slot_ext = 32'(i_slot);
    assign in_slot_ok  = in_slot_ext < 32'(ENTRIES);
    assign out_free    = !r_out_valid || !i_stall;

    // Skip the query's own slot when asked
    assign skip_cur = r_skip && (32'(r_slot) == 32'(r_pidx));

    aabb_box_mem #(
        .DEPTH (ENTRIES),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (mem_rdata)
    );

    aabb_overlap u_cmp (
        .i_query (r_query),
        .i_entry (mem_rdata),
        .i_skip  (skip_cur),
        .o_hit   (cmp_hit)
    );

    // Next state, memory write and output register
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pidx      = r_pidx;
        n_pend      = 1'b0;
        n_hit       = r_hit;
        n_out_valid = r_out_valid;
        n_out_hit   = r_out_hit;
        n_query     = r_query;
        n_slot      = r_slot;
        n_skip      = r_skip;
        mem_we      = 1'b0;
        mem_waddr   = r_idx[IDX_W-1:0];
        mem_wdata   = '0;

        // Drop the result once taken
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_idx == CNT_LAST) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_query = in_box;
                    n_slot  = i_slot;
                    n_skip  = i_skip_self;
                    n_hit   = 1'b0;
                    n_idx   = '0;
                    if (i_op == OP_ADD) begin
                        mem_we    = in_slot_ok;
                        mem_waddr = in_slot_ext[IDX_W-1:0];
                        mem_wdata = '{vld: 1'b1, box: in_box};
                        n_state   = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Issue one read per cycle, compare each word in the cycle after its read
                if (r_idx != CNT_END) begin
                    n_pend = 1'b1;
                    n_pidx = r_idx[IDX_W-1:0];
                    n_idx  = r_idx + 1'b1;
                end
                if (r_pend && cmp_hit) begin
                    n_hit = 1'b1;
                end
                if (r_idx == CNT_END && !r_pend) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_hit;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_hit       <= n_hit;
        end
        r_pidx    <= n_pidx;
        r_out_hit <= n_out_hit;
        r_query   <= n_query;
        r_slot    <= n_slot;
        r_skip    <= n_skip;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_hit   = r_out_hit;

endmodule

### rtl/aabb_checker.sv
// ----------------------------------------------------------------------------
// aabb_checker
// Port-level checks for the box overlap table, bound to the top level.
// ----------------------------------------------------------------------------
module aabb_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic i_op,
    input logic o_valid,
    input logic i_stall,
    input logic o_hit
);
    import aabb_pkg::*;

    logic in_acc;

    assign in_acc = i_valid && !o_stall;

    // Reset leaves no result and holds off input during the clear
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_stall && !o_valid))
        else $error("result or ready right after reset");

    // One item at a time: stall rises after each accepted item
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("second item accepted while one is in work");

    // An add item accepted into an empty output returns a result with hit low
    a_add_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_op == OP_ADD && !o_valid) |=> ##1 (o_valid && !o_hit))
        else $error("add item did not return hit low");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_hit)))
        else $error("stalled result changed");

endmodule

bind aabb_overlap_query_table aabb_checker u_aabb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_op    (i_op),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_hit   (o_hit)
);

### test/tb_aabb_overlap_query_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aabb_overlap_query_table
// Self-checking bench for the 3D box overlap table. A directed set covers the
// empty table, inclusive edge contact, own-slot skipping, slot replacement,
// inverted boxes and full-range coordinates. Random traffic of clustered,
// inverted and noise boxes follows. Each hit flag is compared in order
// against a shadow copy of the table kept in the bench.
// ----------------------------------------------------------------------------
module tb_aabb_overlap_query_table;

    import aabb_pkg::*;

    localparam int ENTRIES      = 64;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = ENTRIES + 16;
    localparam int MAX_IDLE     = 17;

    localparam t_coord ONE   = 32'sh0001_0000;
    localparam t_coord C_MIN = 32'sh8000_0000;
    localparam t_coord C_MAX = 32'sh7fff_ffff;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              o_stall;
    logic              i_op        = OP_ADD;
    logic [SLOT_W-1:0] i_slot      = '0;
    logic              i_skip_self = 1'b0;
    t_coord            i_min_x     = '0;
    t_coord            i_min_y     = '0;
    t_coord            i_min_z     = '0;
    t_coord            i_max_x     = '0;
    t_coord            i_max_y     = '0;
    t_coord            i_max_z     = '0;
    logic              o_valid;
    logic              i_stall     = 1'b0;
    logic              o_hit;

    // Shadow table
    t_box mirror_box  [ENTRIES];
    bit   mirror_live [ENTRIES];

    bit hit_expect_q [$];
    int mismatch_count = 0;
    int result_index   = 0;
    int stall_left     = 0;
    int quiet_cycles   = 0;
    bit idle_on        = 1'b0;

    aabb_overlap_query_table #(
        .ENTRIES(ENTRIES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_op       (i_op),
        .i_slot     (i_slot),
        .i_skip_self(i_skip_self),
        .i_min_x    (i_min_x),
        .i_min_y    (i_min_y),
        .i_min_z    (i_min_z),
        .i_max_x    (i_max_x),
        .i_max_y    (i_max_y),
        .i_max_z    (i_max_z),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_hit      (o_hit)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Closed-range contact on one axis: either minimum lies inside the other range
    function automatic bit axis_touch(t_coord alo, t_coord ahi, t_coord blo, t_coord bhi);
        return ((alo >= blo) && (alo <= bhi)) || ((blo >= alo) && (blo <= ahi));
    endfunction

    function automatic bit boxes_touch(t_box a, t_box b);
        return axis_touch(a.min_x, a.max_x, b.min_x, b.max_x)
            && axis_touch(a.min_y, a.max_y, b.min_y, b.max_y)
            && axis_touch(a.min_z, a.max_z, b.min_z, b.max_z);
    endfunction

    // Apply one item to the shadow table and return the expected hit flag
    function automatic bit apply_to_mirror(logic op, logic [SLOT_W-1:0] slot, logic skip,
                                           t_box q);
        bit hit = 1'b0;
        if (op == OP_ADD) begin
            if (slot < ENTRIES) begin
                mirror_box[slot]  = q;
                mirror_live[slot] = 1'b1;
            end
        end else begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (mirror_live[i] && !(skip && i == slot) && boxes_touch(q, mirror_box[i]))
                    hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic t_box mk_box(t_coord lx, t_coord ly, t_coord lz,
                                    t_coord hx, t_coord hy, t_coord hz);
        t_box b;
        b.min_x = lx;
        b.min_y = ly;
        b.min_z = lz;
        b.max_x = hx;
        b.max_y = hy;
        b.max_z = hz;
        return b;
    endfunction

    function automatic t_box cube(t_coord lo, t_coord hi);
        return mk_box(lo, lo, lo, hi, hi, hi);
    endfunction

    // Mostly small boxes in a shared window so hits and misses both occur;
    // some inverted, some raw 32-bit noise
    function automatic t_box rand_box();
        t_coord lo [3];
        t_coord hi [3];
        t_coord tmp;
        int     mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++) begin
            if (mode == 0) begin
                lo[k] = $urandom;
                hi[k] = $urandom;
            end else begin
                lo[k] = int'($urandom_range(0, (1 << 19) - 1)) - (1 << 18);
                hi[k] = lo[k] + int'($urandom_range(0, 1 << 16));
                if (mode == 1) begin
                    tmp   = lo[k];
                    lo[k] = hi[k];
                    hi[k] = tmp;
                end
            end
        end
        return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Present one item, hold it until accepted, then record its expected hit
    task automatic send_item(logic op, logic [SLOT_W-1:0] slot, logic skip, t_box b);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_slot      <= slot;
        i_skip_self <= skip;
        i_min_x     <= b.min_x;
        i_min_y     <= b.min_y;
        i_min_z     <= b.min_z;
        i_max_x     <= b.max_x;
        i_max_y     <= b.max_y;
        i_max_z     <= b.max_z;
        do @(posedge i_clk); while (o_stall);
        hit_expect_q.push_back(apply_to_mirror(op, slot, skip, b));
    endtask

    // Queries against a table with no valid slot
    task automatic test_empty_table();
        send_item(OP_TEST, 0, 1'b0, cube(C_MIN, C_MAX));
        send_item(OP_TEST, 63, 1'b1, cube(C_MIN, C_MAX));
    endtask

    // Inclusive contact at faces, one-LSB misses and an enclosing query
    task automatic test_edge_contact();
        send_item(OP_ADD, 0, 1'b0, cube(-10 * ONE, 10 * ONE));
        send_item(OP_TEST, 1, 1'b0, cube(10 * ONE, 20 * ONE));
        send_item(OP_TEST, 1, 1'b0, mk_box(10 * ONE + 1, 10 * ONE, 10 * ONE,
                                          20 * ONE, 20 * ONE, 20 * ONE));
        send_item(OP_TEST, 1, 1'b0, mk_box(0, 0, -20 * ONE, 0, 0, -10 * ONE - 1));
        send_item(OP_TEST, 1, 1'b0, cube(C_MIN, C_MAX));
    endtask

    // Own-slot skipping on test
    task automatic test_skip_self();
        send_item(OP_TEST, 0, 1'b1, cube(0, 0));
        send_item(OP_TEST, 0, 1'b0, cube(0, 0));
        send_item(OP_TEST, 1, 1'b1, cube(0, 0));
    endtask

    // Overwrite a slot: the old box must drop out
    task automatic test_replace_slot();
        send_item(OP_ADD, 0, 1'b0, cube(C_MAX - 15, C_MAX));
        send_item(OP_TEST, 5, 1'b0, cube(0, 0));
        send_item(OP_TEST, 5, 1'b0, cube(C_MAX, C_MAX));
    endtask

    // Inverted boxes, stored and queried
    task automatic test_inverted_box();
        send_item(OP_ADD, 63, 1'b0, cube(5 * ONE, -5 * ONE));
        send_item(OP_TEST, 2, 1'b0, cube(0, 0));
        send_item(OP_TEST, 2, 1'b0, cube(5 * ONE, 6 * ONE));
        send_item(OP_TEST, 2, 1'b0, cube(3 * ONE, -100 * ONE));
    endtask

    // Full-range box against extreme corner queries
    task automatic test_full_range();
        send_item(OP_ADD, 62, 1'b0, cube(C_MIN, C_MAX));
        send_item(OP_TEST, 62, 1'b0, cube(C_MIN, C_MIN));
        send_item(OP_TEST, 62, 1'b1, cube(C_MIN, C_MIN));
        send_item(OP_ADD, 62, 1'b0, cube(C_MIN, C_MIN + 1));
    endtask

    // Random adds and tests; idling switched on and off in blocks
    task automatic test_random_traffic(int n_items);
        logic              op;
        logic [SLOT_W-1:0] slot;
        logic              skip;
        t_box              b;
        for (int n = 0; n < n_items; n++) begin
            if (n % 125 == 0)
                idle_on = ((n / 125) % 3 != 2);
            op   = ($urandom_range(0, 9) < 4) ? OP_ADD : OP_TEST;
            slot = SLOT_W'($urandom_range(0, ENTRIES - 1));
            skip = 1'($urandom_range(0, 1));
            b    = rand_box();
            // query a stored box against itself now and then, so skipping matters
            if (op == OP_TEST && mirror_live[slot] && $urandom_range(0, 2) == 0)
                b = mirror_box[slot];
            send_item(op, slot, skip, b);
        end
    endtask

    // Take results and drive random stall
    always @(posedge i_clk) begin : result_check
        bit want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (hit_expect_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d with nothing pending, hit=%b",
                                              result_index, o_hit));
                end else begin
                    want = hit_expect_q.pop_front();
                    if (o_hit !== want)
                        report_mismatch($sformatf("result %0d hit=%b, want %b",
                                                  result_index, o_hit, want));
                end
                result_index++;
                stall_left = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            end
            i_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // End the run when no item moves on either channel for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("aabb_overlap_query_table regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_on = 1'b0;
        test_empty_table();
        test_edge_contact();
        idle_on = 1'b1;
        test_skip_self();
        test_replace_slot();
        idle_on = 1'b0;
        test_inverted_box();
        idle_on = 1'b1;
        test_full_range();
        test_random_traffic(1000);
        i_valid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (hit_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("aabb_overlap_query_table regression: pass");
        else
            $display("aabb_overlap_query_table regression: fail");
        $finish;
    end

endmodule
